[hw/rtl/reflow_profile_sequencer_assert.svh]
// assertion macros for the reflow profile sequencer
// each macro expects clk and rst in scope
`ifndef REFLOW_PROFILE_SEQUENCER_ASSERT_SVH
`define REFLOW_PROFILE_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS
`define RPS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sequencer check failed");
`define RPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sequencer check failed");
`else
`define RPS_ASSERT_SAME(lbl, ante, cons)
`define RPS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[hw/rtl/rps_pkg.sv]
`timescale 1ns / 1ps

package rps_pkg;

  localparam int WINDOW_MS        = 2000;
  localparam int RAMP_INTERVAL_MS = 1000;
  localparam int BUZZER_MS        = 2000;
  localparam int MS_PER_SEC       = 1000;

  typedef enum logic [3:0] {
    PH_READY    = 4'd0,
    PH_TOO_HOT  = 4'd1,
    PH_HEATUP1  = 4'd2,
    PH_SOAK     = 4'd3,
    PH_HEATUP2  = 4'd4,
    PH_REFLOW   = 4'd5,
    PH_COOLDOWN = 4'd6,
    PH_FINISHED = 4'd7,
    PH_ABORTED  = 4'd8
  } phase_t;

  localparam logic [1:0] GAIN_HEATUP = 2'd0;
  localparam logic [1:0] GAIN_SOAK   = 2'd1;
  localparam logic [1:0] GAIN_REFLOW = 2'd2;

  localparam logic [3:0] CFG_HEATUP1_STEP     = 4'd0;
  localparam logic [3:0] CFG_SOAK_TEMP        = 4'd1;
  localparam logic [3:0] CFG_SOAK_SECONDS     = 4'd2;
  localparam logic [3:0] CFG_HEATUP2_STEP     = 4'd3;
  localparam logic [3:0] CFG_REFLOW_TEMP      = 4'd4;
  localparam logic [3:0] CFG_REFLOW_SECONDS   = 4'd5;
  localparam logic [3:0] CFG_COOLDOWN_TEMP    = 4'd6;
  localparam logic [3:0] CFG_START_LIMIT_TEMP = 4'd7;

  typedef struct packed {
    logic [8:0]  heatup1_step;
    logic [11:0] soak_temp;
    logic [9:0]  soak_seconds;
    logic [8:0]  heatup2_step;
    logic [11:0] reflow_temp;
    logic [9:0]  reflow_seconds;
    logic [11:0] cooldown_temp;
    logic [11:0] start_limit_temp;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    heatup1_step:     9'd4,
    soak_temp:        12'd600,
    soak_seconds:     10'd90,
    heatup2_step:     9'd4,
    reflow_temp:      12'd960,
    reflow_seconds:   10'd40,
    cooldown_temp:    12'd400,
    start_limit_temp: 12'd200
  };

  typedef struct packed {
    logic [11:0] temperature;
    logic        start_request;
    logic        abort_request;
    logic [10:0] drive_level;
  } tick_t;

  typedef struct packed {
    logic [3:0]  phase;
    logic [11:0] target;
    logic [1:0]  gain_select;
    logic        heating_active;
    logic        heater_on;
    logic        buzzer_on;
  } result_t;

endpackage

[hw/rtl/rps_cfg_regs.sv]
`timescale 1ns / 1ps

module rps_cfg_regs import rps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr,
  input  logic [3:0]  index,
  input  logic [11:0] data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr) begin
      unique case (index)
        CFG_HEATUP1_STEP:     cfg.heatup1_step     <= data[8:0];
        CFG_SOAK_TEMP:        cfg.soak_temp        <= data;
        CFG_SOAK_SECONDS:     cfg.soak_seconds     <= data[9:0];
        CFG_HEATUP2_STEP:     cfg.heatup2_step     <= data[8:0];
        CFG_REFLOW_TEMP:      cfg.reflow_temp      <= data;
        CFG_REFLOW_SECONDS:   cfg.reflow_seconds   <= data[9:0];
        CFG_COOLDOWN_TEMP:    cfg.cooldown_temp    <= data;
        CFG_START_LIMIT_TEMP: cfg.start_limit_temp <= data;
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/rps_core.sv]
`timescale 1ns / 1ps

`include "reflow_profile_sequencer_assert.svh"

module rps_core import rps_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    step,
  input  tick_t   tick,
  output result_t res
);

  phase_t      phase, phase_next;
  logic [11:0] setpoint, setpoint_next;
  logic [15:0] ramp_timer, ramp_timer_next;
  logic [19:0] hold_timer, hold_timer_next;
  logic [15:0] buzzer_timer, buzzer_timer_next;
  logic [10:0] window_position, window_position_next;
  logic        active_flag, active_flag_next;
  logic [1:0]  gain, gain_next;

  logic        abort_hit;
  logic        too_hot;
  logic [16:0] ramp_inc;
  logic        ramp_due;
  logic [8:0]  ramp_step;
  logic [11:0] ramp_cap;
  logic [11:0] ramp_sum;
  logic [11:0] ramp_val;
  logic [19:0] soak_hold;
  logic [19:0] reflow_hold;
  logic        heat;
  logic        buzz;

  function automatic logic [11:0] sat_add(input logic [11:0] a, input logic [8:0] b);
    logic [12:0] s;
    s = {1'b0, a} + {4'd0, b};
    return s[12] ? 12'hFFF : s[11:0];
  endfunction

  assign abort_hit = tick.abort_request && (phase >= PH_HEATUP1) && (phase <= PH_FINISHED);
  assign too_hot   = tick.temperature >= cfg.start_limit_temp;

  assign ramp_inc  = {1'b0, ramp_timer} + 17'd1;
  assign ramp_due  = ramp_inc >= 17'(RAMP_INTERVAL_MS);
  assign ramp_step = (phase == PH_HEATUP2) ? cfg.heatup2_step : cfg.heatup1_step;
  assign ramp_cap  = (phase == PH_HEATUP2) ? cfg.reflow_temp : cfg.soak_temp;
  assign ramp_sum  = sat_add(setpoint, ramp_step);
  assign ramp_val  = (ramp_sum >= ramp_cap) ? ramp_cap : ramp_sum;

  assign soak_hold   = 20'(cfg.soak_seconds * MS_PER_SEC);
  assign reflow_hold = 20'(cfg.reflow_seconds * MS_PER_SEC);

  // phase transitions
  always_comb begin
    phase_next = phase;
    if (abort_hit) begin
      phase_next = PH_ABORTED;
    end else begin
      unique case (phase) inside
        PH_HEATUP1:  if (tick.temperature >= cfg.soak_temp) phase_next = PH_SOAK;
        PH_SOAK:     if (hold_timer == '0) phase_next = PH_HEATUP2;
        PH_HEATUP2:  if (tick.temperature >= cfg.reflow_temp) phase_next = PH_REFLOW;
        PH_REFLOW:   if (hold_timer == '0) phase_next = PH_COOLDOWN;
        PH_COOLDOWN: if (tick.temperature < cfg.cooldown_temp) phase_next = PH_FINISHED;
        PH_FINISHED: ;
        PH_ABORTED, PH_TOO_HOT: if (!too_hot) phase_next = PH_READY;
        default: begin
          if (too_hot) phase_next = PH_TOO_HOT;
          else if (tick.start_request) phase_next = PH_HEATUP1;
          else phase_next = PH_READY;
        end
      endcase
    end
  end

  // timers, setpoint and outputs
  always_comb begin
    logic [11:0] win_inc;
    logic [11:0] win_wrap;
    setpoint_next        = setpoint;
    ramp_timer_next      = ramp_timer;
    hold_timer_next      = hold_timer;
    buzzer_timer_next    = buzzer_timer;
    window_position_next = window_position;
    active_flag_next     = active_flag;
    gain_next            = gain;
    buzz                 = 1'b0;
    heat                 = 1'b0;

    if (buzzer_timer != '0) begin
      buzz              = 1'b1;
      buzzer_timer_next = buzzer_timer - 16'd1;
    end

    if (abort_hit) begin
      active_flag_next = 1'b0;
    end else begin
      unique case (phase) inside
        PH_HEATUP1: begin
          active_flag_next = 1'b1;
          if (ramp_due) begin
            ramp_timer_next = '0;
            setpoint_next   = ramp_val;
          end else begin
            ramp_timer_next = ramp_inc[15:0];
          end
          if (tick.temperature >= cfg.soak_temp) begin
            hold_timer_next = soak_hold;
            setpoint_next   = cfg.soak_temp;
            gain_next       = GAIN_SOAK;
          end
        end
        PH_SOAK: begin
          if (hold_timer == '0) begin
            setpoint_next   = sat_add(tick.temperature, cfg.heatup2_step);
            // first heatup2 tick takes a ramp step at once
            ramp_timer_next = 16'(RAMP_INTERVAL_MS - 1);
            gain_next       = GAIN_HEATUP;
          end else begin
            hold_timer_next = hold_timer - 20'd1;
          end
        end
        PH_HEATUP2: begin
          if (ramp_due) begin
            ramp_timer_next = '0;
            setpoint_next   = ramp_val;
          end else begin
            ramp_timer_next = ramp_inc[15:0];
          end
          if (tick.temperature >= cfg.reflow_temp) begin
            hold_timer_next = reflow_hold;
            setpoint_next   = cfg.reflow_temp;
            gain_next       = GAIN_REFLOW;
          end
        end
        PH_REFLOW: begin
          if (hold_timer == '0) begin
            setpoint_next     = cfg.cooldown_temp;
            buzzer_timer_next = 16'(BUZZER_MS);
            buzz              = 1'b1;
          end else begin
            hold_timer_next = hold_timer - 20'd1;
          end
        end
        PH_COOLDOWN: begin
          if (tick.temperature < cfg.cooldown_temp) active_flag_next = 1'b0;
        end
        PH_FINISHED: ;
        PH_ABORTED, PH_TOO_HOT: begin
          active_flag_next = 1'b0;
        end
        default: begin
          if (!too_hot && tick.start_request) begin
            setpoint_next        = sat_add(tick.temperature, cfg.heatup1_step);
            ramp_timer_next      = '0;
            window_position_next = '0;
            gain_next            = GAIN_HEATUP;
          end
        end
      endcase
    end

    // heater window runs 1..WINDOW_MS while active
    win_inc  = {1'b0, window_position_next} + 12'd1;
    win_wrap = (win_inc > 12'(WINDOW_MS)) ? win_inc - 12'(WINDOW_MS) : win_inc;
    if (active_flag_next) begin
      window_position_next = win_wrap[10:0];
      heat                 = tick.drive_level > win_wrap[10:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_READY;
      setpoint        <= '0;
      ramp_timer      <= '0;
      hold_timer      <= '0;
      buzzer_timer    <= '0;
      window_position <= '0;
      active_flag     <= 1'b0;
      gain            <= GAIN_HEATUP;
    end else if (step) begin
      phase           <= phase_next;
      setpoint        <= setpoint_next;
      ramp_timer      <= ramp_timer_next;
      hold_timer      <= hold_timer_next;
      buzzer_timer    <= buzzer_timer_next;
      window_position <= window_position_next;
      active_flag     <= active_flag_next;
      gain            <= gain_next;
    end
  end

  assign res.phase          = phase_next;
  assign res.target         = setpoint_next;
  assign res.gain_select    = gain_next;
  assign res.heating_active = active_flag_next;
  assign res.heater_on      = heat;
  assign res.buzzer_on      = buzz;

  `RPS_ASSERT_SAME(a_aborted_idle, phase == PH_ABORTED, !active_flag)
  `RPS_ASSERT_SAME(a_window_range, 1'b1, window_position <= 11'(WINDOW_MS))
  `RPS_ASSERT_SAME(a_buzzer_range, 1'b1, buzzer_timer <= 16'(BUZZER_MS))
  `RPS_ASSERT_NEXT(a_cool_done,
    step && !tick.abort_request && phase == PH_COOLDOWN &&
    tick.temperature < cfg.cooldown_temp,
    phase == PH_FINISHED && !active_flag)

endmodule

[hw/rtl/reflow_profile_sequencer.sv]
`timescale 1ns / 1ps

// reflow profile sequencer, one beat per millisecond tick
// tick channel: temperature, start and abort requests and the drive level of
// the external controller; each accepted beat yields exactly one result beat
// result channel: phase, setpoint, gain set, active flag, heater and buzzer
// cfg channel: register index and data; always ready, write only while idle
// path: an accepted tick beat is taken into the input register, then the phase
// logic writes its result into the result register
// throughput: one tick per cycle while results are taken; the whole profile
// step is one pass of compares, one saturating add and the timer updates
// reset: phase ready, setpoint and all timers zero, heatup gains, heater
// off, registers back to their default profile
// stall: a waiting result holds the result register; the input register
// still takes one more tick, then ready drops until the result is taken
module reflow_profile_sequencer import rps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        tick_valid,
  output logic        tick_ready,
  input  tick_t       tick,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  cfg_t    cfg;
  result_t res;
  tick_t   held_tick;
  logic    held_valid;
  logic    advance;
  logic    step;

  assign cfg_ready  = 1'b1;
  assign advance    = !result_valid || result_ready;
  assign tick_ready = !held_valid || advance;
  assign step       = held_valid && advance;

  rps_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr    (cfg_valid && cfg_ready),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  rps_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (step),
    .tick (held_tick),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (tick_ready) held_valid <= tick_valid;
      if (advance) result_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_ready && tick_valid) held_tick <= tick;
    if (step) result <= res;
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
  import rps_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  // index outside the register map, must be a no-op
  localparam logic [3:0] CFG_UNUSED = 4'd15;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        tick_valid = 1'b0;
  logic        tick_ready;
  tick_t       tick = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  result_t     result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;

  reflow_profile_sequencer u_top (
    .clk, .rst, .tick_valid, .tick_ready, .tick, .result_valid, .result_ready,
    .result, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #5 clk = ~clk;

  // oven profile shadow state
  cfg_t        prof_cfg      = CFG_RESET;
  phase_t      prof_phase    = PH_READY;
  logic [11:0] prof_setpoint = '0;
  logic [15:0] ramp_ms       = '0;
  logic [19:0] hold_ms       = '0;
  logic [15:0] buzz_ms       = '0;
  logic [10:0] window_ms     = '0;
  logic        prof_active   = 1'b0;
  logic [1:0]  prof_gain     = GAIN_HEATUP;

  tick_t   tick_backlog[$];
  result_t status_due[$];
  int      queued = 0;
  int      fault_count = 0;
  int      idle_cycles = 0;
  bit      calm_stretch = 1'b0;
  // runs queued while set carry no stray aborts
  bit      abort_free = 1'b0;

  function automatic logic [11:0] clamp_sum(input logic [11:0] a, input logic [8:0] b);
    logic [12:0] s;
    s = {1'b0, a} + {4'd0, b};
    return (s > 13'd4095) ? 12'd4095 : s[11:0];
  endfunction

  function automatic void ramp_tick(input logic [8:0] step, input logic [11:0] cap);
    ramp_ms = ramp_ms + 16'd1;
    if (ramp_ms >= 16'(RAMP_INTERVAL_MS)) begin
      ramp_ms = '0;
      prof_setpoint = clamp_sum(prof_setpoint, step);
      if (prof_setpoint >= cap) prof_setpoint = cap;
    end
  endfunction

  function automatic result_t advance_profile(input tick_t t);
    result_t     r;
    logic        buzz;
    logic        heat;
    logic [11:0] pos;
    buzz = 1'b0;
    heat = 1'b0;
    if (buzz_ms != '0) begin
      buzz = 1'b1;
      buzz_ms = buzz_ms - 16'd1;
    end
    if (t.abort_request && prof_phase >= PH_HEATUP1 && prof_phase <= PH_FINISHED) begin
      prof_phase = PH_ABORTED;
      prof_active = 1'b0;
    end else begin
      case (prof_phase)
        PH_HEATUP1: begin
          prof_active = 1'b1;
          ramp_tick(prof_cfg.heatup1_step, prof_cfg.soak_temp);
          if (t.temperature >= prof_cfg.soak_temp) begin
            hold_ms = 20'(prof_cfg.soak_seconds * MS_PER_SEC);
            prof_setpoint = prof_cfg.soak_temp;
            prof_gain = GAIN_SOAK;
            prof_phase = PH_SOAK;
          end
        end
        PH_SOAK: begin
          if (hold_ms == '0) begin
            prof_setpoint = clamp_sum(t.temperature, prof_cfg.heatup2_step);
            // first heatup2 tick takes a ramp step at once
            ramp_ms = 16'(RAMP_INTERVAL_MS - 1);
            prof_gain = GAIN_HEATUP;
            prof_phase = PH_HEATUP2;
          end else begin
            hold_ms = hold_ms - 20'd1;
          end
        end
        PH_HEATUP2: begin
          ramp_tick(prof_cfg.heatup2_step, prof_cfg.reflow_temp);
          if (t.temperature >= prof_cfg.reflow_temp) begin
            hold_ms = 20'(prof_cfg.reflow_seconds * MS_PER_SEC);
            prof_setpoint = prof_cfg.reflow_temp;
            prof_gain = GAIN_REFLOW;
            prof_phase = PH_REFLOW;
          end
        end
        PH_REFLOW: begin
          if (hold_ms == '0) begin
            prof_setpoint = prof_cfg.cooldown_temp;
            prof_phase = PH_COOLDOWN;
            buzz_ms = 16'(BUZZER_MS);
            buzz = 1'b1;
          end else begin
            hold_ms = hold_ms - 20'd1;
          end
        end
        PH_COOLDOWN: begin
          if (t.temperature < prof_cfg.cooldown_temp) begin
            prof_active = 1'b0;
            prof_phase = PH_FINISHED;
          end
        end
        PH_FINISHED: ;
        PH_ABORTED, PH_TOO_HOT: begin
          prof_active = 1'b0;
          if (t.temperature < prof_cfg.start_limit_temp) prof_phase = PH_READY;
        end
        default: begin
          prof_phase = PH_READY;
          if (t.temperature >= prof_cfg.start_limit_temp) begin
            prof_phase = PH_TOO_HOT;
          end else if (t.start_request) begin
            prof_setpoint = clamp_sum(t.temperature, prof_cfg.heatup1_step);
            ramp_ms = '0;
            window_ms = '0;
            prof_gain = GAIN_HEATUP;
            prof_phase = PH_HEATUP1;
          end
        end
      endcase
    end
    if (prof_active) begin
      pos = {1'b0, window_ms} + 12'd1;
      if (pos > 12'(WINDOW_MS)) pos = pos - 12'(WINDOW_MS);
      window_ms = pos[10:0];
      heat = t.drive_level > window_ms;
    end
    r.phase = prof_phase;
    r.target = prof_setpoint;
    r.gain_select = prof_gain;
    r.heating_active = prof_active;
    r.heater_on = heat;
    r.buzzer_on = buzz;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 299) == 0) calm_stretch = !calm_stretch;
    if (calm_stretch) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [10:0] pick_drive();
    case ($urandom_range(0, 9))
      0: return 11'd0;
      1: return 11'd2047;
      2: return 11'($urandom_range(1995, 2005));
      default: return 11'($urandom_range(0, 2047));
    endcase
  endfunction

  function automatic logic [11:0] temp_below(input logic [11:0] lim);
    return (lim == '0) ? 12'd0 : 12'($urandom_range(0, lim - 12'd1));
  endfunction

  function automatic logic [11:0] temp_from(input logic [11:0] lim);
    return 12'($urandom_range(lim, 4095));
  endfunction

  function automatic logic [11:0] temp_any();
    return 12'($urandom_range(0, 4095));
  endfunction

  task automatic queue_tick(input logic [11:0] temp, input logic start, input logic abort_req,
                            input logic [10:0] drive);
    tick_t t;
    t.temperature = temp;
    t.start_request = start;
    t.abort_request = abort_req;
    t.drive_level = drive;
    tick_backlog.push_back(t);
    queued++;
  endtask

  // tick inside a run: stray starts are ignored, rare aborts break the run
  task automatic run_tick(input logic [11:0] temp);
    queue_tick(temp, $urandom_range(0, 3) == 0, !abort_free && $urandom_range(0, 199) == 0,
               pick_drive());
  endtask

  // one full profile run shaped by the current register settings
  task automatic add_run(input int h1_len, input int h2_len);
    int soak_len;
    int reflow_len;
    soak_len = (prof_cfg.soak_seconds > 2) ? 20 : prof_cfg.soak_seconds * MS_PER_SEC + 1;
    reflow_len = (prof_cfg.reflow_seconds > 2) ? 20 : prof_cfg.reflow_seconds * MS_PER_SEC + 1;
    repeat ($urandom_range(1, 3))
      queue_tick(temp_below(prof_cfg.start_limit_temp), 1'b0, 1'($urandom % 2), pick_drive());
    queue_tick(temp_below(prof_cfg.start_limit_temp), 1'b1, 1'b0, pick_drive());
    repeat (h1_len) run_tick(temp_below(prof_cfg.soak_temp));
    run_tick(temp_from(prof_cfg.soak_temp));
    repeat (soak_len) run_tick(temp_any());
    repeat (h2_len) run_tick(temp_below(prof_cfg.reflow_temp));
    run_tick(temp_from(prof_cfg.reflow_temp));
    repeat (reflow_len) run_tick(temp_any());
    repeat ($urandom_range(0, 4)) run_tick(temp_from(prof_cfg.cooldown_temp));
    run_tick(temp_below(prof_cfg.cooldown_temp));
    repeat ($urandom_range(0, 3)) run_tick(temp_any());
    queue_tick(temp_any(), 1'($urandom % 2), 1'b1, pick_drive());
    repeat ($urandom_range(0, 3))
      queue_tick(temp_from(prof_cfg.start_limit_temp), 1'($urandom % 2), 1'($urandom % 2),
                 pick_drive());
    queue_tick(temp_below(prof_cfg.start_limit_temp), 1'b0, 1'($urandom % 2), pick_drive());
  endtask

  task automatic fill_phase(input int n_items, input int max_len);
    int first;
    first = queued;
    while (queued - first < n_items) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(5, 25))
          queue_tick(temp_any(), 1'($urandom % 2), $urandom_range(0, 7) == 0, pick_drive());
      end else begin
        add_run($urandom_range(0, max_len), $urandom_range(0, max_len));
      end
    end
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [11:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_HEATUP1_STEP:     prof_cfg.heatup1_step = val[8:0];
      CFG_SOAK_TEMP:        prof_cfg.soak_temp = val;
      CFG_SOAK_SECONDS:     prof_cfg.soak_seconds = val[9:0];
      CFG_HEATUP2_STEP:     prof_cfg.heatup2_step = val[8:0];
      CFG_REFLOW_TEMP:      prof_cfg.reflow_temp = val;
      CFG_REFLOW_SECONDS:   prof_cfg.reflow_seconds = val[9:0];
      CFG_COOLDOWN_TEMP:    prof_cfg.cooldown_temp = val;
      CFG_START_LIMIT_TEMP: prof_cfg.start_limit_temp = val;
      default: ;
    endcase
  endtask

  task automatic load_profile(input logic [11:0] h1_step, input logic [11:0] soak_t,
                              input logic [11:0] soak_s, input logic [11:0] h2_step,
                              input logic [11:0] reflow_t, input logic [11:0] reflow_s,
                              input logic [11:0] cool_t, input logic [11:0] limit_t);
    write_reg(CFG_HEATUP1_STEP, h1_step);
    write_reg(CFG_SOAK_TEMP, soak_t);
    write_reg(CFG_SOAK_SECONDS, soak_s);
    write_reg(CFG_HEATUP2_STEP, h2_step);
    write_reg(CFG_REFLOW_TEMP, reflow_t);
    write_reg(CFG_REFLOW_SECONDS, reflow_s);
    write_reg(CFG_COOLDOWN_TEMP, cool_t);
    write_reg(CFG_START_LIMIT_TEMP, limit_t);
  endtask

  // wait until every tick is sent and every status beat is back, then let the pipe empty
  task automatic drain();
    do @(negedge clk); while (tick_backlog.size() != 0 || tick_valid || status_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(input string what, input logic [11:0] want,
                             input logic [11:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      fault_count++;
    end
  endtask

  // tick driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (tick_valid && tick_ready) status_due.push_back(advance_profile(tick));
      if (!tick_valid || tick_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          tick_valid <= 1'b0;
        end else if (tick_backlog.size() != 0) begin
          tick <= tick_backlog.pop_front();
          tick_valid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          tick_valid <= 1'b0;
        end
      end
    end
  end

  // status monitor
  int hold_off = 0;
  always @(posedge clk) begin : status_mon
    result_t want;
    if (rst) begin
      result_ready <= 1'b0;
      hold_off = 0;
    end else begin
      if (result_valid && result_ready) begin
        if (status_due.size() == 0) begin
          $display("%0t: status beat with nothing outstanding, phase %0d target %0d",
                   $time, result.phase, result.target);
          fault_count++;
        end else begin
          want = status_due.pop_front();
          check_field("phase", 12'(want.phase), 12'(result.phase));
          check_field("target", want.target, result.target);
          check_field("gain_select", 12'(want.gain_select), 12'(result.gain_select));
          check_field("heating_active", 12'(want.heating_active),
                      12'(result.heating_active));
          check_field("heater_on", 12'(want.heater_on), 12'(result.heater_on));
          check_field("buzzer_on", 12'(want.buzzer_on), 12'(result.buzzer_on));
        end
      end
      if (hold_off > 0) begin
        hold_off--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) hold_off = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (tick_valid && tick_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int lim;
    int soak_t;
    int refl_t;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // default profile: ready, too hot, start, abort paths
    queue_tick(12'd0, 1'b0, 1'b0, 11'd0);
    queue_tick(12'd0, 1'b0, 1'b1, 11'd2047);
    queue_tick(12'd4095, 1'b1, 1'b0, 11'd0);
    queue_tick(12'd199, 1'b1, 1'b1, 11'd0);
    queue_tick(12'd200, 1'b1, 1'b0, 11'd0);
    queue_tick(12'd0, 1'b0, 1'b0, 11'd0);
    queue_tick(12'd199, 1'b1, 1'b0, 11'd2047);
    queue_tick(12'd100, 1'b1, 1'b0, 11'd0);
    queue_tick(12'd599, 1'b0, 1'b0, 11'd2000);
    queue_tick(12'd300, 1'b0, 1'b0, 11'd2047);
    queue_tick(12'd600, 1'b1, 1'b0, 11'd2);
    queue_tick(12'd4095, 1'b1, 1'b0, 11'd2047);
    queue_tick(12'd0, 1'b0, 1'b1, 11'd0);
    queue_tick(12'd4095, 1'b1, 1'b1, 11'd0);
    queue_tick(12'd0, 1'b0, 1'b0, 11'd0);
    drain();

    // zero holds: walk every phase but too hot, abort from finished
    write_reg(CFG_UNUSED, 12'hfff);
    write_reg(CFG_SOAK_SECONDS, 12'd0);
    write_reg(CFG_REFLOW_SECONDS, 12'd0);
    queue_tick(12'd150, 1'b1, 1'b0, 11'd1000);
    queue_tick(12'd599, 1'b0, 1'b0, 11'd1000);
    queue_tick(12'd600, 1'b0, 1'b0, 11'd1000);
    queue_tick(12'd1234, 1'b0, 1'b0, 11'd1000);
    queue_tick(12'd959, 1'b1, 1'b0, 11'd1000);
    queue_tick(12'd960, 1'b0, 1'b0, 11'd1000);
    queue_tick(12'd0, 1'b0, 1'b0, 11'd1000);
    queue_tick(12'd400, 1'b0, 1'b0, 11'd1000);
    queue_tick(12'd399, 1'b1, 1'b0, 11'd1000);
    queue_tick(12'd4095, 1'b1, 1'b0, 11'd0);
    queue_tick(12'd4095, 1'b0, 1'b1, 11'd0);
    queue_tick(12'd100, 1'b0, 1'b0, 11'd0);
    drain();

    load_profile(12'($urandom_range(0, 400)), 12'd600, 12'd0, 12'($urandom_range(0, 400)),
                 12'd960, 12'd0, 12'd400, 12'd200);
    fill_phase(100, 20);
    drain();

    lim = $urandom_range(1, 1500);
    soak_t = $urandom_range(lim, 3000);
    refl_t = $urandom_range(soak_t, 4095);
    load_profile(12'($urandom_range(0, 400)), 12'(soak_t), 12'd0, 12'($urandom_range(0, 400)),
                 12'(refl_t), 12'd0, 12'($urandom_range(1, refl_t)), 12'(lim));
    fill_phase(100, 30);
    drain();

    // top of every temperature range: saturating setpoint, too hot only at full scale
    load_profile(12'd400, 12'd4095, 12'd0, 12'd400, 12'd4095, 12'd0, 12'd4095, 12'd4095);
    fill_phase(120, 10);
    drain();

    // all zero: the oven never leaves too hot
    load_profile(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
    fill_phase(40, 5);
    drain();

    // longest holds, runs stall in soak until aborted
    load_profile(12'($urandom_range(0, 400)), 12'd600, 12'd1023, 12'($urandom_range(0, 400)),
                 12'd960, 12'd1023, 12'd400, 12'd200);
    fill_phase(100, 10);
    drain();

    // a full ramp interval in heatup1, run kept free of aborts
    load_profile(12'($urandom_range(1, 40)), 12'd600, 12'd0, 12'($urandom_range(1, 40)),
                 12'd960, 12'd0, 12'd400, 12'd200);
    add_run(3, 3);
    abort_free = 1'b1;
    add_run(1050, 20);
    abort_free = 1'b0;
    drain();

    repeat (10) @(posedge clk);
    if (fault_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
